[rtl/three_point_delta_kernel_weight_top_assert.svh]
// assertion macros for the delta kernel block
`ifndef THREE_POINT_DELTA_KERNEL_WEIGHT_TOP_ASSERT_SVH
`define THREE_POINT_DELTA_KERNEL_WEIGHT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TPD_ASSERT_IMPL(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TPD_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPD_ASSERT_IMPL(label, clk, rstn, prop, msg)
`define TPD_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

[rtl/tpd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package tpd_pkg;
  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned OffW = 32;
  localparam int unsigned SpcW = 32;
  localparam int unsigned WtW = 16;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegSpacingX = 1'b0;
  localparam logic [CfgIdxW-1:0] RegSpacingY = 1'b1;
  localparam logic [SpcW-1:0] SpacingRst = 32'd65536;
endpackage
`default_nettype wire

[rtl/tpd_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface tpd_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] offset_x;
  logic signed [31:0] offset_y;
  modport source (output valid, output offset_x, output offset_y, input ready);
  modport sink (input valid, input offset_x, input offset_y, output ready);
endinterface
`default_nettype wire

[rtl/tpd_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface tpd_out_if;
  logic valid;
  logic ready;
  logic [15:0] weight;
  modport source (output valid, output weight, input ready);
  modport sink (input valid, input weight, output ready);
endinterface
`default_nettype wire

[rtl/tpd_axis.sv]
`timescale 1ns / 1ps
`default_nettype none
// one axis: pipelined restoring divide, then pipelined isqrt, then band formula
// all stages advance on en_i; stage count is fixed by the parameter
module tpd_axis
  import tpd_pkg::*;
#(
  parameter int unsigned FracBits = FracBitsDef,
  localparam int unsigned RW = FracBits + 2,
  localparam int unsigned SqW = 2 * FracBits + 2,
  localparam int unsigned SrW = FracBits + 1,
  localparam int unsigned NDiv = RW,
  localparam int unsigned NSq = SrW
) (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [31:0] off_i,
  input  wire logic [SpcW-1:0]    spc_i,
  output logic [FracBits-1:0]     w_o
);
  localparam int unsigned MagW = 33;
  localparam int unsigned NumW = MagW + FracBits;
  localparam logic [RW-1:0] Cap = RW'(2) << FracBits;
  localparam logic [RW-1:0] OneF = RW'(1) << FracBits;
  localparam logic [RW-1:0] Half = RW'(1) << (FracBits - 1);
  // x / 3 as (x * ceil(2^RcS / 3)) >> RcS, exact for x below 2^(RcS-1)
  localparam int unsigned RcS = FracBits + 4;
  localparam logic [RcS-1:0] Recip3 = RcS'(((64'd1 << RcS) + 64'd2) / 64'd3);
  localparam logic [1:0] SelZero = 2'd0;
  localparam logic [1:0] SelInner = 2'd1;
  localparam logic [1:0] SelMid = 2'd2;

  // divider stages: remainder, quotient, numerator, spacing
  // quotient bits above RW only matter as "over cap", kept as sticky flag
  logic [SpcW:0]     dr_q [NDiv+1];
  logic [RW-1:0]     dq_q [NDiv+1];
  logic [NumW-1:0]   dn_q [NDiv+1];
  logic [SpcW-1:0]   ds_q [NDiv+1];
  logic              dov_q [NDiv+1];

  logic [MagW-1:0] mag;
  logic [NumW-1:0] numv;
  assign mag = off_i[31] ? MagW'(-{off_i[31], off_i}) : MagW'(off_i);
  assign numv = NumW'(mag) << FracBits;

  // the top NumW-RW numerator bits are resolved by a compare in stage 0
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dn_q[0] <= numv;
      ds_q[0] <= spc_i;
      dq_q[0] <= '0;
      // quotient >= 2^RW iff num >> RW >= spc
      dov_q[0] <= (spc_i == '0) || (SpcW'(numv[NumW-1:RW]) >= spc_i);
      // without overflow the high bits are already below spacing
      dr_q[0] <= (SpcW+1)'(numv[NumW-1:RW]);
    end
  end

  for (genvar k = 0; k < NDiv; k++) begin : g_div
    logic [SpcW+1:0] tr;
    logic            ge;
    assign tr = {dr_q[k], dn_q[k][NumW-1-(NumW-RW)-k]};
    assign ge = tr >= {2'b00, ds_q[k]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        // remainder stays below spacing
        dr_q[k+1] <= ge ? (SpcW+1)'(tr - {2'b00, ds_q[k]}) : (SpcW+1)'(tr);
        dq_q[k+1] <= {dq_q[k][RW-2:0], ge};
        dn_q[k+1] <= dn_q[k];
        ds_q[k+1] <= ds_q[k];
        dov_q[k+1] <= dov_q[k];
      end
    end
  end

  // ratio and band select
  logic [RW-1:0] r;
  assign r = (dov_q[NDiv] || dq_q[NDiv] > Cap) ? Cap : dq_q[NDiv];

  logic [RW-1:0] dd;
  logic          inner, mid;
  assign inner = r <= Half;
  assign mid   = r <= RW'(3) * Half;
  assign dd    = inner ? r : (r > OneF ? RW'(r - OneF) : RW'(OneF - r));

  // isqrt pipeline, one result bit per stage; entry 0 holds 1 - 3*d*d
  logic [SqW-1:0] sv_q [NSq+1];
  logic [SqW-1:0] sres_q [NSq+1];
  logic [RW-1:0]  sr_q [NSq+1];
  logic           si_q [NSq+1];
  logic           sm_q [NSq+1];
  logic [2*RW+1:0] sq3;
  assign sq3 = (2*RW+2)'(3) * (2*RW+2)'(dd) * (2*RW+2)'(dd);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sv_q[0] <= (SqW'(1) << (2 * FracBits)) - SqW'(sq3);
      sres_q[0] <= '0;
      sr_q[0] <= r;
      si_q[0] <= inner;
      sm_q[0] <= mid;
    end
  end
  for (genvar k = 0; k < NSq; k++) begin : g_sq
    localparam logic [SqW-1:0] Bit = SqW'(1) << (2 * (NSq - 1 - k));
    logic [SqW-1:0] t;
    assign t = sres_q[k] + Bit;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (sv_q[k] >= t) begin
          sv_q[k+1] <= sv_q[k] - t;
          sres_q[k+1] <= (sres_q[k] >> 1) + Bit;
        end else begin
          sv_q[k+1] <= sv_q[k];
          sres_q[k+1] <= sres_q[k] >> 1;
        end
        sr_q[k+1] <= sr_q[k];
        si_q[k+1] <= si_q[k];
        sm_q[k+1] <= sm_q[k];
      end
    end
  end

  // numerator, then divide by constant
  logic [SrW+2:0] s;
  logic signed [RW+4:0] num;
  logic [RW+3:0] numu_q;
  logic [1:0] sel_q;
  assign s = (SrW+3)'(sres_q[NSq]);
  assign num = (RW+5)'(5) * (RW+5)'(OneF) - (RW+5)'(3) * (RW+5)'(sr_q[NSq])
               - (RW+5)'(s);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (si_q[NSq]) begin
        numu_q <= (RW+4)'(OneF) + (RW+4)'(s);
        sel_q <= SelInner;
      end else if (sm_q[NSq]) begin
        numu_q <= num[RW+4] ? '0 : (RW+4)'(num);
        sel_q <= SelMid;
      end else begin
        numu_q <= '0;
        sel_q <= SelZero;
      end
    end
  end

  // divide by 3, and by 6 as a further halving
  logic [RW+RcS+3:0] prod3;
  logic [FracBits:0] q3;
  logic [FracBits-1:0] w_q;
  assign prod3 = (RW+RcS+4)'(numu_q) * (RW+RcS+4)'(Recip3);
  assign q3 = (FracBits+1)'(prod3 >> RcS);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (sel_q)
        SelInner: w_q <= FracBits'(q3);
        SelMid:   w_q <= FracBits'(q3 >> 1);
        default:  w_q <= '0;
      endcase
    end
  end
  assign w_o = w_q;
endmodule
`default_nettype wire

[rtl/three_point_delta_kernel_weight_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  payload
// in       in   offset_x, offset_y (signed Q16.16)
// out      out  weight (unsigned Q0.16)
// cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i (spacing_x, spacing_y)
// one item per cycle while the output is not stalled; the divider and square root
// pipelines resolve one bit per stage
// the whole pipe stalls together when the output register is full and not taken
// reset clears valid bits and sets both spacings to 1.0
module three_point_delta_kernel_weight_top
  import tpd_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = FracBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [SpcW-1:0]    cfg_data_i,
  tpd_in_if.sink                  in_if,
  tpd_out_if.source               out_if
);
`include "three_point_delta_kernel_weight_top_assert.svh"
  localparam int unsigned Lat = 2 * FRACTION_BITS + 8;
  logic [SpcW-1:0] spx_q, spy_q;
  logic [Lat-1:0] vld_q;
  logic en;
  logic [FRACTION_BITS-1:0] wx, wy;
  logic [2*FRACTION_BITS-1:0] prod_q;
  logic pv_q;

  assign en = !vld_q[Lat-1] || !out_if.valid || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spx_q <= SpacingRst;
      spy_q <= SpacingRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegSpacingX: spx_q <= cfg_data_i;
        RegSpacingY: spy_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tpd_axis #(.FracBits(FRACTION_BITS)) u_ax (
    .clk_i, .en_i(en), .off_i(in_if.offset_x), .spc_i(spx_q), .w_o(wx));
  tpd_axis #(.FracBits(FRACTION_BITS)) u_ay (
    .clk_i, .en_i(en), .off_i(in_if.offset_y), .spc_i(spy_q), .w_o(wy));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_if.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) prod_q <= wx * wy;
  end
  assign pv_q = vld_q[Lat-1];
  assign out_if.valid = pv_q;
  assign out_if.weight = WtW'(prod_q >> (2 * FRACTION_BITS - 16));

  `TPD_ASSERT_IMPL(a_hold, clk_i, rst_ni,
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.weight),
    "output changed while stalled")
  `TPD_ASSERT_IMPL(a_cap, clk_i, rst_ni,
    out_if.valid |-> out_if.weight <= 16'd29127, "weight above 4/9")
  `TPD_ASSERT_IMPL(a_rdy, clk_i, rst_ni,
    !out_if.valid |-> in_if.ready, "stalled with empty output")
endmodule
`default_nettype wire
